### hw/rtl/spe_pkg.sv
// Shared constants, types and codes for the spinlock pool engine.
// No dependencies; spinlock_pool_engine and spe_checker import this package.
`timescale 1ns / 1ps

package spe_pkg;

	localparam int NUM_LOCKS    = 1024;
	localparam int IDX_W        = 10;
	localparam int ADDR_SPACE   = 1 << IDX_W;
	localparam int SEARCH_LIMIT = (NUM_LOCKS < ADDR_SPACE) ? NUM_LOCKS : ADDR_SPACE;

	// Entries are packed 32 to a memory row, two bits each.
	localparam int ROW_ENTRIES = 32;
	localparam int COL_W       = 5;
	localparam int ROW_W       = 2 * ROW_ENTRIES;
	localparam int ROWS        = (SEARCH_LIMIT + ROW_ENTRIES - 1) / ROW_ENTRIES;
	localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int STATUS_W = 2;
	localparam int REQ_W    = 3;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 3'd0,
		REQ_RELEASE = 3'd1,
		REQ_LOCK    = 3'd2,
		REQ_TRYLOCK = 3'd3,
		REQ_UNLOCK  = 3'd4
	} req_e_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_BUSY   = 2'd1,
		STS_NOFREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_INVALID  = 2'd0,
		ST_UNLOCKED = 2'd1,
		ST_LOCKED   = 2'd2
	} entry_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_READ,
		FSM_MODIFY
	} fsm_t;

endpackage

### hw/rtl/spe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/spinlock_pool_engine.sv
// Top level of the spinlock pool engine: request sequencer, row memory and
// full-row summary. Depends on spe_pkg and spe_ram.
`timescale 1ns / 1ps
//
// Channel   Dir  Beat contents (low bit up)
// --------  ---  -------------------------------------------------------
// s_axis    in   tuser: req_type[2:0]; tdata: lock_index[9:0], zero pad
// m_axis    out  tdata: status[1:0], granted_index[11:2], zero pad
//
// A request passes through accept, row read, then modify and write back to
// the single-port-per-direction row memory (one row read and at most one row
// write per request). The next request is taken once the write lands.
// After reset a clearing pass writes every row (32 at 1024 locks) to invalid,
// with s_axis_tready low. A result beat waiting in the output register
// does not block a new request; only a second finished result holds the
// modify stage until m_axis_tready frees the register.

module spinlock_pool_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [spe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // lock_index[9:0], pad
	input  logic [spe_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type[2:0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [spe_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // status[1:0], granted_index[11:2]
);

	import spe_pkg::*;

	fsm_t              state_q, state_d;
	logic [ROW_AW-1:0] clr_q;
	req_e_t            req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ROW_AW-1:0] row_q;
	logic              inrange_q;
	logic              nofree_q;
	logic [ROWS-1:0]   full_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              accept;
	logic              advance;
	logic [IDX_W-1:0]  in_idx;
	logic [ROW_AW-1:0] alloc_row;
	logic              all_full;

	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  rd_row;

	logic [ROW_W-1:0]  new_row;
	logic              row_we;
	status_t           sts;
	logic [IDX_W-1:0]  granted;
	logic [ROW_ENTRIES-1:0] free_old;
	logic [ROW_ENTRIES-1:0] free_new;
	logic [COL_W-1:0]  hit;
	entry_t            cur;
	logic [COL_W-1:0]  col;

	assign in_idx        = s_axis_tdata[IDX_W-1:0];
	assign s_axis_tready = (state_q == FSM_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	// Modify stage may finish only when the output register is free or draining.
	assign advance       = (state_q == FSM_MODIFY) && (!out_valid_q || m_axis_tready);

	// Lowest row that still holds an invalid entry.
	always_comb begin
		alloc_row = '0;
		all_full  = &full_q;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (!full_q[r]) begin
				alloc_row = ROW_AW'(r);
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (clr_q == ROW_AW'(ROWS - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_READ;
				end
			end
			FSM_READ: begin
				state_d = FSM_MODIFY;
			end
			FSM_MODIFY: begin
				if (advance) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_CLEAR;
			end
		endcase
	end

	// Capture the request; allocate picks its row here from the summary.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_e_t'(s_axis_tuser);
			idx_q     <= in_idx;
			inrange_q <= (32'(in_idx) < NUM_LOCKS);
			nofree_q  <= all_full;
			if (req_e_t'(s_axis_tuser) == REQ_ALLOC) begin
				row_q <= alloc_row;
			end else begin
				row_q <= ROW_AW'(in_idx >> COL_W);
			end
		end
	end

	// Row memory: clearing pass owns the write port until the sweep ends.
	assign ram_we    = (state_q == FSM_CLEAR) || (advance && row_we);
	assign ram_waddr = (state_q == FSM_CLEAR) ? clr_q : row_q;
	assign ram_wdata = (state_q == FSM_CLEAR) ? '0 : new_row;

	spe_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(row_q),
		.rdata(rd_row)
	);

	// Free mask of the row as read; entries past the search limit never count.
	always_comb begin
		for (int k = 0; k < ROW_ENTRIES; k++) begin
			free_old[k] = (rd_row[2*k +: 2] == ST_INVALID) &&
				((int'(row_q) * ROW_ENTRIES + k) < SEARCH_LIMIT);
		end
		hit = '0;
		for (int k = ROW_ENTRIES - 1; k >= 0; k--) begin
			if (free_old[k]) begin
				hit = COL_W'(k);
			end
		end
	end

	assign col = idx_q[COL_W-1:0];
	assign cur = entry_t'(rd_row[2*col +: 2]);

	// Modify: decide the new entry state, the status and the returned index.
	always_comb begin
		new_row = rd_row;
		row_we  = 1'b0;
		sts     = STS_OK;
		granted = idx_q;
		unique case (req_q)
			REQ_ALLOC: begin
				if (nofree_q) begin
					sts = STS_NOFREE;
				end else begin
					new_row[2*hit +: 2] = ST_UNLOCKED;
					row_we  = 1'b1;
					granted = IDX_W'(int'(row_q) * ROW_ENTRIES + int'(hit));
				end
			end
			REQ_RELEASE, REQ_LOCK, REQ_TRYLOCK, REQ_UNLOCK: begin
				if (!inrange_q) begin
					sts = STS_NOFREE;
				end else begin
					case (req_q)
						REQ_RELEASE: begin
							new_row[2*col +: 2] = ST_INVALID;
							row_we = 1'b1;
						end
						REQ_LOCK: begin
							if (cur == ST_LOCKED) begin
								sts = STS_BUSY;
							end else begin
								new_row[2*col +: 2] = ST_LOCKED;
								row_we = 1'b1;
							end
						end
						REQ_TRYLOCK: begin
							if (cur == ST_UNLOCKED) begin
								new_row[2*col +: 2] = ST_LOCKED;
								row_we = 1'b1;
							end else begin
								sts = STS_BUSY;
							end
						end
						default: begin
							new_row[2*col +: 2] = ST_UNLOCKED;
							row_we = 1'b1;
						end
					endcase
				end
			end
			default: begin
				// unknown request: drop it, report success
			end
		endcase
		for (int k = 0; k < ROW_ENTRIES; k++) begin
			free_new[k] = (new_row[2*k +: 2] == ST_INVALID) &&
				((int'(row_q) * ROW_ENTRIES + k) < SEARCH_LIMIT);
		end
	end

	// Summary of rows with no invalid entry left; reset matches the cleared memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (advance && row_we) begin
			full_q[row_q] <= ~|free_new;
		end
	end

	// Output register: load on advance, drop valid once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= OUT_TDATA_W'({granted, sts});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/spe_checker.sv
// Port-level checker for the spinlock pool engine, bound to the top level.
// Depends on spe_pkg and spinlock_pool_engine.
`timescale 1ns / 1ps

module spe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [spe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import spe_pkg::*;

	// One request in flight: ready drops right after an accepted beat.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a request is in flight");

	// A fresh result beat follows its accepted request through the read and modify states.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
		else $error("result beat without matching request");

	// Status is one of the defined codes and the pad bits stay zero.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] != 2'd3) &&
			(m_axis_tdata[OUT_TDATA_W-1:STATUS_W+IDX_W] == '0))
		else $error("malformed result beat");

	// Stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind spinlock_pool_engine spe_checker u_spe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

### bench/spinlock_pool_engine_test.sv
// Self-checking bench for spinlock_pool_engine: a lock ledger mirrors the entry
// bank, predicts every result beat and checks the m_axis stream in order.
// Depends on spe_pkg and the RTL under hw/rtl; reads no files.
`timescale 1ns / 1ps

import spe_pkg::*;

typedef struct packed {
	status_t             status;
	logic [IDX_W-1:0]    granted;
} grant_t;

// Mirror of the entry bank plus the queue of result beats still owed.
class lock_ledger;
	entry_t      mirror[NUM_LOCKS];
	grant_t      due[$];
	int unsigned mismatches;
	int unsigned beats_checked;
	int unsigned requests_by_code[8];
	int unsigned full_allocs;

	function new();
		foreach (mirror[i]) mirror[i] = ST_INVALID;
		foreach (requests_by_code[i]) requests_by_code[i] = 0;
		mismatches = 0;
		beats_checked = 0;
		full_allocs = 0;
	endfunction

	task report_mismatch(input string what);
		$display("MISMATCH beat %0d: %s", beats_checked, what);
		mismatches++;
	endtask

	function bit bank_full();
		bit any_free;
		any_free = 1'b0;
		for (int i = 0; i < SEARCH_LIMIT; i++)
			if (mirror[i] == ST_INVALID) any_free = 1'b1;
		return !any_free;
	endfunction

	function int outstanding();
		return due.size();
	endfunction

	// Apply one accepted request to the mirror and queue the beat it owes.
	function void take_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
		grant_t g;
		bit     found;
		g.status = STS_OK;
		g.granted = idx;
		found = 1'b0;
		requests_by_code[req]++;
		if (req == REQ_ALLOC) begin
			for (int i = 0; i < SEARCH_LIMIT; i++) begin
				if (!found && mirror[i] == ST_INVALID) begin
					mirror[i] = ST_UNLOCKED;
					g.granted = i[IDX_W-1:0];
					found = 1'b1;
				end
			end
			if (!found) begin
				g.status = STS_NOFREE;
				full_allocs++;
			end
		end else if (req <= REQ_UNLOCK) begin
			if (idx >= NUM_LOCKS) begin
				g.status = STS_NOFREE;
			end else begin
				case (req)
					REQ_RELEASE: mirror[idx] = ST_INVALID;
					REQ_LOCK: begin
						if (mirror[idx] == ST_LOCKED) g.status = STS_BUSY;
						else mirror[idx] = ST_LOCKED;
					end
					REQ_TRYLOCK: begin
						if (mirror[idx] == ST_UNLOCKED) mirror[idx] = ST_LOCKED;
						else g.status = STS_BUSY;
					end
					default: mirror[idx] = ST_UNLOCKED;
				endcase
			end
		end
		due.push_back(g);
	endfunction

	// Compare one result beat with the oldest owed grant.
	task check_grant(input logic [OUT_TDATA_W-1:0] beat);
		grant_t want;
		if (due.size() == 0) begin
			report_mismatch($sformatf("unexpected beat 0x%04h", beat));
		end else begin
			want = due.pop_front();
			if (beat[STATUS_W-1:0] !== want.status)
				report_mismatch($sformatf("status expected %0d got %0d",
					want.status, beat[STATUS_W-1:0]));
			if (beat[IDX_W+STATUS_W-1:STATUS_W] !== want.granted)
				report_mismatch($sformatf("granted_index expected %0d got %0d",
					want.granted, beat[IDX_W+STATUS_W-1:STATUS_W]));
		end
		beats_checked++;
	endtask
endclass

module spinlock_pool_engine_test;

	localparam int          CYCLE_LIMIT   = 300000;
	localparam int          SETTLE_CYCLES = 16;
	localparam logic [2:0]  REQ_FIRST_UNUSED = 3'd5;
	localparam logic [2:0]  REQ_SPARE_CODE   = 3'd6;
	localparam logic [2:0]  REQ_LAST_CODE    = 3'd7;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;   // lock_index[9:0], zero pad
	logic [REQ_W-1:0]        s_axis_tuser;   // req_type[2:0]
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // status[1:0], granted_index[11:2], zero pad

	lock_ledger  ledger;
	bit          idle_on;
	int unsigned cycle_count;
	int          stall_left;

	spinlock_pool_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog: a run that hangs on a handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed",
				cycle_count, ledger.outstanding());
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: ready is high except for random stall bursts
	// while idling is on. Change it only on the falling edge.
	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 3);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check every result beat at the rising edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_grant(m_axis_tdata);
	end

	function automatic logic [IDX_W-1:0] rand_index(input int lo, input int hi);
		int r;
		r = $urandom_range(lo, hi);
		return r[IDX_W-1:0];
	endfunction

	// Present one request beat and hold it until the engine takes it. An
	// optional idle burst goes first, with noise on tdata.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, rand_index(0, ADDR_SPACE-1)};
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
		do @(posedge clk); while (!s_axis_tready);
		ledger.take_request(req, idx);
	endtask

	// Drop valid and hold the sender until every owed beat has come back.
	task automatic drain_grants();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
	endtask

	// Contended spin: a second lock on a held entry answers busy, the
	// holder unlocks and the retry wins.
	task automatic spin_on_entry(input logic [IDX_W-1:0] idx);
		send_request(REQ_LOCK, idx);
		send_request(REQ_LOCK, idx);
		send_request(REQ_UNLOCK, idx);
		send_request(REQ_LOCK, idx);
		send_request(REQ_UNLOCK, idx);
	endtask

	// One random request or a contended spin, mostly aimed at a window of low
	// entries so that requests collide on the same lock.
	task automatic send_mixed(input int span);
		int               pick;
		logic [IDX_W-1:0] idx;
		logic [REQ_W-1:0] req;
		int               code;
		idx = ($urandom_range(0, 9) == 0) ? rand_index(0, ADDR_SPACE-1)
			: rand_index(0, span-1);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			spin_on_entry(idx);
		end else begin
			if (pick < 22) req = REQ_ALLOC;
			else if (pick < 34) req = REQ_RELEASE;
			else if (pick < 56) req = REQ_LOCK;
			else if (pick < 74) req = REQ_TRYLOCK;
			else if (pick < 96) req = REQ_UNLOCK;
			else begin
				code = $urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE);
				req = code[REQ_W-1:0];
			end
			send_request(req, idx);
		end
	endtask

	initial begin
		int n;

		ledger = new();
		idle_on = 1'b1;
		cycle_count = 0;
		stall_left = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;

		// Single reset; the engine then runs its clearing pass with tready low,
		// which the first handshake simply waits out.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every operation, top and bottom index, unknown codes.
		send_request(REQ_UNLOCK,  10'h3FF);  // unlock on invalid entry
		send_request(REQ_TRYLOCK, 10'h3FF);  // now unlocked: trylock wins
		send_request(REQ_TRYLOCK, 10'h3FF);  // held: busy
		send_request(REQ_LOCK,    10'h3FF);  // held: busy
		send_request(REQ_UNLOCK,  10'h3FF);
		send_request(REQ_RELEASE, 10'h3FF);
		send_request(REQ_TRYLOCK, 10'h3FF);  // invalid entry: busy
		send_request(REQ_LOCK,    10'h000);  // lock takes an invalid entry
		send_request(REQ_ALLOC,   10'h3FF);  // index field ignored, gets 1
		send_request(REQ_ALLOC,   10'h000);  // gets 2
		send_request(REQ_RELEASE, 10'h000);  // release a locked entry
		send_request(REQ_ALLOC,   10'h2AA);  // lowest free is 0 again
		send_request(REQ_LOCK,    10'h000);
		send_request(REQ_RELEASE, 10'h001);  // release an unlocked entry
		send_request(REQ_RELEASE, 10'h155);  // release an invalid entry
		send_request(REQ_FIRST_UNUSED, 10'h2AA);
		send_request(REQ_SPARE_CODE, 10'h155);
		send_request(REQ_LAST_CODE, 10'h3FF);
		send_request(REQ_TRYLOCK, 10'h002);
		send_request(REQ_UNLOCK,  10'h002);
		send_request(REQ_ALLOC,   10'h155);  // fills the hole at 1
		send_request(REQ_RELEASE, 10'h000);
		send_request(REQ_RELEASE, 10'h001);
		send_request(REQ_RELEASE, 10'h002);

		// Contended traffic on a small window, with idling on both sides.
		for (n = 0; n < 100; n++)
			send_mixed(16);

		// Hold the sender until the engine has answered everything.
		drain_grants();

		// Fill the bank: mostly allocates, some locks scattered over the whole
		// range. Idling switches on and off in stretches of 64 requests.
		n = 0;
		while (!ledger.bank_full()) begin
			idle_on = ((n / 64) % 2) == 0;
			if ($urandom_range(0, 9) == 0)
				send_request(REQ_LOCK, rand_index(0, ADDR_SPACE-1));
			else
				send_request(REQ_ALLOC, rand_index(0, ADDR_SPACE-1));
			n++;
		end
		idle_on = 1'b1;

		// Allocate on a full bank answers no-free and echoes the index.
		for (n = 0; n < 8; n++)
			send_request(REQ_ALLOC, rand_index(0, ADDR_SPACE-1));

		// Punch holes anywhere in the full bank and refill them.
		for (n = 0; n < 40; n++) begin
			send_request(REQ_RELEASE, rand_index(0, ADDR_SPACE-1));
			send_request(REQ_ALLOC, rand_index(0, ADDR_SPACE-1));
			send_mixed(ADDR_SPACE);
		end

		for (n = 0; n < 60; n++)
			send_mixed(64);

		// Last stretch at full rate on both sides.
		idle_on = 1'b0;
		for (n = 0; n < 100; n++)
			send_mixed(32);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d allocate (%0d on a full bank), %0d release, %0d lock, %0d trylock",
			ledger.requests_by_code[REQ_ALLOC], ledger.full_allocs,
			ledger.requests_by_code[REQ_RELEASE], ledger.requests_by_code[REQ_LOCK],
			ledger.requests_by_code[REQ_TRYLOCK]);
		$display("plus %0d unlock and %0d unknown-code requests; %0d beats checked, %0d mismatches",
			ledger.requests_by_code[REQ_UNLOCK],
			ledger.requests_by_code[REQ_FIRST_UNUSED] +
				ledger.requests_by_code[REQ_SPARE_CODE] +
				ledger.requests_by_code[REQ_LAST_CODE],
			ledger.beats_checked, ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
